@@ rtl/sfda_pkg.sv @@
// Shared types and constants for the sparse face diagonal accumulator.
`default_nettype none
package sfda_pkg;

    // Width of every cell index field.
    localparam int IDX_W = 10;
    // Width of a Q16.16 value.
    localparam int DATA_W = 32;
    // Width of the action field and of the mode register.
    localparam int CODE_W = 2;
    // Default number of cells in the accumulator store.
    localparam int CELL_COUNT_DEF = 1024;

    typedef enum logic [CODE_W-1:0] {
        ACT_LOAD  = 2'd0,
        ACT_APPLY = 2'd1,
        ACT_READ  = 2'd2
    } t_action;

    typedef enum logic [CODE_W-1:0] {
        MODE_ADD  = 2'd0,
        MODE_SUB  = 2'd1,
        MODE_SWAP = 2'd2
    } t_mode;

endpackage
`default_nettype wire

@@ rtl/sfda_ram.sv @@
// Generic single write port, single read port RAM with a registered read.
`default_nettype none
module sfda_ram #(
    parameter int WIDTH = sfda_pkg::DATA_W,
    parameter int DEPTH = sfda_pkg::CELL_COUNT_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data holds until the next read enable.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

@@ rtl/sparse_face_diagonal_accumulate_core.sv @@
// Top level of the sparse face diagonal accumulator: cell store and face sequencer.
`default_nettype none
// Channel     Direction  Handshake                   Payload
// ---------   ---------  --------------------------  -----------------------------------------
// input       in         i_in_valid / o_in_ready     i_action, i_cell_index, i_cell_value,
//                                                    i_lower_cell, i_upper_cell,
//                                                    i_lower_coeff, i_upper_coeff
// output      out        o_out_valid / i_out_ready   o_read_value, o_overflow_seen
// config      in         i_cfg_wr_en (no wait)       i_cfg_wr_data (accumulate mode)
//
// A load beat is written into the cell RAM at the edge that accepts it.
// A face beat reads the first cell, then updates it while the second is read, then updates
// the second. The single read port and single write port of the cell RAM set this order;
// a second update of the same cell takes the first sum by forwarding.
// A read beat fetches its cell, then moves it to the output register once that register
// is free of a stalled result. Load and face beats are accepted while a result waits.
// Reset (synchronous, active low) clears the control state, the mode and the sticky overflow
// flag; the cell store is not cleared and must be loaded before use.
module sparse_face_diagonal_accumulate_core #(
    parameter int CELL_COUNT = sfda_pkg::CELL_COUNT_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Input beats
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic        [sfda_pkg::CODE_W-1:0]  i_action,
    input  wire logic        [sfda_pkg::IDX_W-1:0]   i_cell_index,
    input  wire logic signed [sfda_pkg::DATA_W-1:0]  i_cell_value,
    input  wire logic        [sfda_pkg::IDX_W-1:0]   i_lower_cell,
    input  wire logic        [sfda_pkg::IDX_W-1:0]   i_upper_cell,
    input  wire logic signed [sfda_pkg::DATA_W-1:0]  i_lower_coeff,
    input  wire logic signed [sfda_pkg::DATA_W-1:0]  i_upper_coeff,
    // Result beats
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic signed      [sfda_pkg::DATA_W-1:0]  o_read_value,
    output logic                                     o_overflow_seen,
    // Mode register
    input  wire logic                                i_cfg_wr_en,
    input  wire logic        [sfda_pkg::CODE_W-1:0]  i_cfg_wr_data
);

    localparam int AW = $clog2(CELL_COUNT);
    localparam int XW = (AW > sfda_pkg::IDX_W) ? AW : sfda_pkg::IDX_W;
    localparam int DW = sfda_pkg::DATA_W;
    localparam logic [31:0] CELL_LIMIT = 32'(CELL_COUNT);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_F1,
        S_F2
    } t_state;

    typedef struct packed {
        logic [DW-1:0] value;
        logic          ovf;
    } t_sat;

    // Index to RAM address, widened or narrowed to the store's address width.
    function automatic logic [AW-1:0] to_addr(input logic [sfda_pkg::IDX_W-1:0] idx);
        logic [XW-1:0] wide;
        wide = XW'(idx);
        return wide[AW-1:0];
    endfunction

    function automatic logic in_range(input logic [sfda_pkg::IDX_W-1:0] idx);
        return 32'(idx) < CELL_LIMIT;
    endfunction

    // Exact sum of a cell and a 33-bit delta, clamped to the signed 32-bit range.
    function automatic t_sat sat_add(input logic [DW-1:0] base, input logic [DW:0] delta);
        logic [DW+1:0] sum;
        t_sat          res;
        sum = {base[DW-1], base[DW-1], base} + {delta[DW], delta};
        if (sum[DW+1:DW-1] == 3'b000 || sum[DW+1:DW-1] == 3'b111) begin
            res.value = sum[DW-1:0];
            res.ovf   = 1'b0;
        end else begin
            res.value = sum[DW+1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
            res.ovf   = 1'b1;
        end
        return res;
    endfunction

    t_state         r_state;
    logic [1:0]     r_mode;
    logic           r_overflow;
    logic           r_out_valid;
    logic [DW-1:0]  r_out_value;
    logic           r_out_ovf;
    logic           r_rd_ok;
    // Face update operands: first cell A, then cell B.
    logic [AW-1:0]  r_a_addr;
    logic           r_a_ok;
    logic [DW:0]    r_a_delta;
    logic [AW-1:0]  r_b_addr;
    logic           r_b_ok;
    logic [DW:0]    r_b_delta;
    logic           r_same;
    logic [DW-1:0]  r_sum_a;

    logic           accept;
    logic           face_go;
    logic [sfda_pkg::IDX_W-1:0] n_a_idx;
    logic [sfda_pkg::IDX_W-1:0] n_b_idx;
    logic [DW:0]    n_a_delta;
    logic [DW:0]    n_b_delta;
    logic [DW:0]    lo_ext;
    logic [DW:0]    up_ext;
    logic [DW-1:0]  f2_base;
    t_sat           n_sat_a;
    t_sat           n_sat_b;
    logic           out_free;

    logic           ram_wr_en;
    logic [AW-1:0]  ram_wr_addr;
    logic [DW-1:0]  ram_wr_data;
    logic           ram_rd_en;
    logic [AW-1:0]  ram_rd_addr;
    logic [DW-1:0]  ram_rd_data;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    assign lo_ext = {i_lower_coeff[DW-1], i_lower_coeff};
    assign up_ext = {i_upper_coeff[DW-1], i_upper_coeff};

    // Order and sign of the two updates follow the mode register.
    always_comb begin
        face_go   = 1'b1;
        n_a_idx   = i_lower_cell;
        n_b_idx   = i_upper_cell;
        n_a_delta = lo_ext;
        n_b_delta = up_ext;
        case (r_mode)
            sfda_pkg::MODE_ADD: begin
            end
            sfda_pkg::MODE_SUB: begin
                n_a_delta = -lo_ext;
                n_b_delta = -up_ext;
            end
            sfda_pkg::MODE_SWAP: begin
                n_a_idx   = i_upper_cell;
                n_b_idx   = i_lower_cell;
                n_a_delta = i_lower_coeff[DW-1] ? -lo_ext : lo_ext;
                n_b_delta = i_upper_coeff[DW-1] ? -up_ext : up_ext;
            end
            default: begin
                // The unused mode leaves the store untouched.
                face_go = 1'b0;
            end
        endcase
    end

    // The first update is taken from RAM; the second forwards it when both name one cell.
    assign n_sat_a = sat_add(ram_rd_data, r_a_delta);
    assign f2_base = r_same ? r_sum_a : ram_rd_data;
    assign n_sat_b = sat_add(f2_base, r_b_delta);

    // RAM port control.
    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = to_addr(i_cell_index);
        ram_wr_data = i_cell_value;
        ram_rd_en   = 1'b0;
        ram_rd_addr = to_addr(i_cell_index);
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_action)
                        sfda_pkg::ACT_LOAD: begin
                            ram_wr_en = in_range(i_cell_index);
                        end
                        sfda_pkg::ACT_APPLY: begin
                            ram_rd_en   = face_go;
                            ram_rd_addr = to_addr(n_a_idx);
                        end
                        sfda_pkg::ACT_READ: begin
                            ram_rd_en = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_F1: begin
                ram_wr_en   = r_a_ok;
                ram_wr_addr = r_a_addr;
                ram_wr_data = n_sat_a.value;
                ram_rd_en   = 1'b1;
                ram_rd_addr = r_b_addr;
            end
            S_F2: begin
                ram_wr_en   = r_b_ok;
                ram_wr_addr = r_b_addr;
                ram_wr_data = n_sat_b.value;
            end
            default: begin
            end
        endcase
    end

    sfda_ram #(
        .WIDTH(DW),
        .DEPTH(CELL_COUNT)
    ) u_cell_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= sfda_pkg::MODE_ADD;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            // A taken result frees the output register; in S_RD a free register is
            // reloaded with the next result instead.
            if (r_out_valid && i_out_ready && r_state != S_RD) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_action)
                            sfda_pkg::ACT_APPLY: begin
                                r_a_addr  <= to_addr(n_a_idx);
                                r_a_ok    <= in_range(n_a_idx);
                                r_a_delta <= n_a_delta;
                                r_b_addr  <= to_addr(n_b_idx);
                                r_b_ok    <= in_range(n_b_idx);
                                r_b_delta <= n_b_delta;
                                r_same    <= (n_a_idx == n_b_idx);
                                if (face_go) begin
                                    r_state <= S_F1;
                                end
                            end
                            sfda_pkg::ACT_READ: begin
                                r_rd_ok <= in_range(i_cell_index);
                                r_state <= S_RD;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_RD: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_value <= r_rd_ok ? ram_rd_data : '0;
                        r_out_ovf   <= r_overflow;
                        r_state     <= S_IDLE;
                    end
                end
                S_F1: begin
                    r_sum_a <= n_sat_a.value;
                    if (r_a_ok && n_sat_a.ovf) begin
                        r_overflow <= 1'b1;
                    end
                    r_state <= S_F2;
                end
                S_F2: begin
                    if (r_b_ok && n_sat_b.ovf) begin
                        r_overflow <= 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_read_value    = r_out_value;
    assign o_overflow_seen = r_out_ovf;

endmodule
`default_nettype wire

@@ rtl/sfda_checker.sv @@
// Port-level checker for the sparse face diagonal accumulator, bound to the top level.
`default_nettype none
module sfda_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         o_in_ready,
    input wire logic [sfda_pkg::CODE_W-1:0]  i_action,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [sfda_pkg::DATA_W-1:0]  o_read_value,
    input wire logic                         o_overflow_seen
);

    // Synchronous reset empties the output register.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

    // A stalled result holds its value.
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_read_value)
            && $stable(o_overflow_seen))
        else $error("stalled result changed");

    // The overflow flag is sticky: once shown it never drops on a later result.
    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overflow_seen |=> !o_out_valid || o_overflow_seen)
        else $error("overflow flag dropped");

    // A load beat completes at once, so the next beat can follow.
    a_load_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_action == sfda_pkg::ACT_LOAD |=> o_in_ready)
        else $error("load beat held the input");

    // A read beat keeps the input busy while its cell is fetched.
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_action == sfda_pkg::ACT_READ |=> !o_in_ready)
        else $error("read beat did not occupy the sequencer");

endmodule

bind sparse_face_diagonal_accumulate_core sfda_checker u_sfda_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .i_action        (i_action),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_read_value    (o_read_value),
    .o_overflow_seen (o_overflow_seen)
);
`default_nettype wire
